FILE: sv/cqins_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqins_pkg: shared types and constants
// Ring size, field types, operation codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cqins_pkg;

	localparam int DEPTH  = 16;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef logic [SLOT_W-1:0]        slot_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [1:0]               op_t;

	localparam op_t OP_ENQ = 2'd0;
	localparam op_t OP_DEQ = 2'd1;
	localparam op_t OP_INS = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

	typedef struct packed {
		logic res_valid;
	} status_t;

endpackage
`default_nettype wire

FILE: sv/cqins_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqins_req_if: request channel
// Valid/ready channel carrying one queue operation per transaction.
// ----------------------------------------------------------------------------
interface cqins_req_if;
	logic             valid;
	logic             ready;
	cqins_pkg::op_t   op;
	cqins_pkg::data_t data;
	cqins_pkg::slot_t slot;

	modport source (output valid, output op, output data, output slot, input ready);
	modport sink   (input valid, input op, input data, input slot, output ready);
endinterface
`default_nettype wire

FILE: sv/cqins_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqins_rsp_if: response channel
// Valid/ready channel carrying one operation result per transaction.
// ----------------------------------------------------------------------------
interface cqins_rsp_if;
	logic              valid;
	logic              ready;
	logic              accepted;
	cqins_pkg::data_t  read_data;
	cqins_pkg::count_t count;

	modport source (output valid, output accepted, output read_data, output count, input ready);
	modport sink   (input valid, input accepted, input read_data, input count, output ready);
endinterface
`default_nettype wire

FILE: sv/cqins_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqins_ctrl: operation sequencer
// Captures a request, then issues the execute step once the result
// register is free or being drained.
// ----------------------------------------------------------------------------
module cqins_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               out_ready,
	input  wire cqins_pkg::status_t status,
	output cqins_pkg::cmd_t         cmd
);
	import cqins_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// result register free, or its content leaves this cycle
				if (!status.res_valid || out_ready) begin
					cmd.execute = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_exec_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && !status.res_valid) |=> (state_q == ST_IDLE))
		else $error("execute step stalled with an empty result register");

endmodule
`default_nettype wire

FILE: sv/cqins_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqins_dp: ring storage, pointers and result register
// Entries form a row of registers; an insert shifts the occupied span
// between the target slot and the tail one place onward in one step.
// ----------------------------------------------------------------------------
module cqins_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cqins_pkg::cmd_t     cmd,
	output cqins_pkg::status_t       status,
	input  wire cqins_pkg::op_t      op,
	input  wire cqins_pkg::data_t    data,
	input  wire cqins_pkg::slot_t    slot,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic                     out_accepted,
	output cqins_pkg::data_t         out_read_data,
	output cqins_pkg::count_t        out_count
);
	import cqins_pkg::*;

	// captured request
	op_t    op_q;
	data_t  data_q;
	slot_t  slot_q;

	// queue state
	data_t  ring_q [DEPTH];
	slot_t  head_q;
	slot_t  tail_q;
	count_t count_q;

	// result register
	logic   res_valid_q;
	logic   res_accepted_q;
	data_t  res_data_q;
	count_t res_count_q;

	logic   full;
	logic   empty;
	logic   is_put;
	logic   put_ok;
	logic   get_ok;
	logic   op_ok;
	slot_t  off_slot;
	count_t off;
	count_t count_nxt;
	logic   load_sel  [DEPTH];
	logic   shift_sel [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			data_q <= data;
			slot_q <= slot;
		end
	end

	always_comb begin
		full     = (count_q == count_t'(DEPTH));
		empty    = (count_q == '0);
		is_put   = (op_q == OP_ENQ) || (op_q == OP_INS);
		off_slot = slot_q - head_q;
		// enqueue targets the tail, i.e. offset equal to the count
		off      = (op_q == OP_ENQ) ? count_q : count_t'(off_slot);
		put_ok   = is_put && !full && (off <= count_q);
		get_ok   = (op_q == OP_DEQ) && !empty;
		op_ok    = put_ok || get_ok;
		if (put_ok) begin
			count_nxt = count_q + count_t'(1);
		end else if (get_ok) begin
			count_nxt = count_q - count_t'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	// per-entry select from its offset relative to head; the offset wraps
	// at the slot width before it is widened
	always_comb begin
		slot_t rel;
		for (int i = 0; i < DEPTH; i++) begin
			rel          = slot_t'(i) - head_q;
			load_sel[i]  = (count_t'(rel) == off);
			shift_sel[i] = (count_t'(rel) > off) && (count_t'(rel) <= count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && put_ok) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (load_sel[i]) begin
					ring_q[i] <= data_q;
				end else if (shift_sel[i]) begin
					ring_q[i] <= ring_q[slot_t'(i + DEPTH - 1)];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_nxt;
			if (put_ok) begin
				tail_q <= tail_q + slot_t'(1);
			end
			if (get_ok) begin
				head_q <= head_q + slot_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_accepted_q <= op_ok;
			res_data_q     <= get_ok ? ring_q[head_q] : '0;
			res_count_q    <= count_nxt;
		end
	end

	assign status.res_valid = res_valid_q;
	assign out_valid        = res_valid_q;
	assign out_accepted     = res_accepted_q;
	assign out_read_data    = res_data_q;
	assign out_count        = res_count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(DEPTH))
		else $error("held count above ring depth");

	a_tail_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == slot_t'(head_q + slot_t'(count_q)))
		else $error("tail not at head plus count");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && !op_ok) |=>
			($stable(head_q) && $stable(tail_q) && $stable(count_q)))
		else $error("rejected operation changed queue state");

endmodule
`default_nettype wire

FILE: sv/circular_queue_with_insert_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_queue_with_insert_core: ring FIFO with slot insertion
// Signed 32-bit ring queue with enqueue, dequeue and insert at an absolute
// slot; each request yields one response with status, data and new count.
// ----------------------------------------------------------------------------
//
//   channel | dir | fields                       | handshake
//   --------+-----+------------------------------+------------
//   req     | in  | op, data, slot               | valid/ready
//   rsp     | out | accepted, read_data, count   | valid/ready
//
// Steps: each transaction is captured from req, then executed against the
//   ring registers (insert shifts the held cells past the target at once).
// The result register decouples the sides: the next request is captured
//   while a response still waits on rsp.
// Stalls: with rsp.ready low and a response pending, the execute step waits.
// Reset clears head, tail, count and response valid; ring entries are not
//   cleared, since only held entries are ever read.
// ----------------------------------------------------------------------------
module circular_queue_with_insert_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cqins_req_if.sink   req,
	cqins_rsp_if.source rsp
);
	import cqins_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: request capture and execute timing
	cqins_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// ring, pointers and response register
	cqins_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.op            (req.op),
		.data          (req.data),
		.slot          (req.slot),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_accepted  (rsp.accepted),
		.out_read_data (rsp.read_data),
		.out_count     (rsp.count)
	);

endmodule
`default_nettype wire
